/* rtl/nnue_accumulator_screlu_eval_core_assert.svh */
`ifndef NNUE_ACCUMULATOR_SCRELU_EVAL_CORE_ASSERT_SVH
`define NNUE_ACCUMULATOR_SCRELU_EVAL_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define NNUE_ASSERT_NOW(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");

// next-cycle implication, checked at every edge
`define NNUE_ASSERT_NEXT(lbl, clk, a, c) \
  lbl: assert property (@(posedge clk) (a) |=> (c)) \
    else $error("assertion failed");

`endif

/* rtl/nnue_pkg.sv */
package nnue_pkg;

  localparam int LANES      = 256;
  localparam int INPUT_DIM  = 1024;
  localparam int LANE_W     = $clog2(LANES);
  localparam int HEAD_DEPTH = 2 * LANES;
  localparam int HEAD_W     = $clog2(HEAD_DEPTH);
  localparam int ROW_DEPTH  = INPUT_DIM * LANES;
  localparam int ROW_AW     = $clog2(ROW_DEPTH);
  localparam int WIDE_W     = 98;

  typedef enum logic [2:0] {
    OP_LOAD_W    = 3'd0,
    OP_LOAD_BIAS = 3'd1,
    OP_LOAD_HEAD = 3'd2,
    OP_RESET     = 3'd3,
    OP_ADD       = 3'd4,
    OP_SUB       = 3'd5,
    OP_EVAL      = 3'd6
  } op_t;

  typedef enum logic [2:0] {
    K_NOP,
    K_WR_ROW,
    K_WR_BIAS,
    K_WR_HEAD,
    K_RESET,
    K_ADD,
    K_SUB,
    K_EVAL
  } kind_t;

  typedef enum logic [1:0] {
    CFG_CLAMP = 2'd0,
    CFG_GAIN  = 2'd1,
    CFG_BIAS  = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    kind_t              kind;
    logic               side;
    logic [ROW_AW-1:0]  row_addr;
    logic [8:0]         lane;
    logic signed [15:0] w16;
    logic [31:0]        v32;
    logic               status;
  } cmd_t;

  typedef struct packed {
    logic        we;
    logic [1:0]  index;
    logic [63:0] data;
  } cfg_wr_t;

endpackage

/* rtl/nnue_queue.sv */
module nnue_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  nnue_pkg::cmd_t push_cmd,
  input  logic          pop,
  output nnue_pkg::cmd_t head_cmd,
  output logic          not_empty,
  output logic          full
);
  import nnue_pkg::*;

  cmd_t       q_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;

  assign head_cmd  = q_r[rd_ptr_r];
  assign not_empty = (count_r != 2'd0);
  assign full      = (count_r == 2'd2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop) rd_ptr_r <= ~rd_ptr_r;
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wr_ptr_r] <= push_cmd;
  end

endmodule

/* rtl/nnue_front.sv */
module nnue_front (
  input  logic               start,
  input  logic [2:0]         in_op,
  input  logic               in_perspective,
  input  logic [16:0]        in_feature_index,
  input  logic [8:0]         in_lane_index,
  input  logic signed [31:0] in_value,
  input  logic               q_full,
  output logic               busy,
  output logic               push,
  output nnue_pkg::cmd_t     cmd
);
  import nnue_pkg::*;

  logic fi_ok;
  logic lane_ok;
  logic head_ok;

  function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
    if (v > 32'sd32767) return 16'sh7fff;
    if (v < -32'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  assign busy    = q_full;
  assign push    = start && !q_full;
  assign fi_ok   = (18'(in_feature_index) < 18'(INPUT_DIM));
  assign lane_ok = (10'(in_lane_index) < 10'(LANES));
  assign head_ok = (11'(in_lane_index) < 11'(HEAD_DEPTH));

  always_comb begin
    cmd.side     = in_perspective;
    cmd.row_addr = ROW_AW'(in_feature_index) * ROW_AW'(LANES);
    cmd.lane     = in_lane_index;
    cmd.w16      = sat16(in_value);
    cmd.v32      = in_value;
    cmd.status   = 1'b0;
    cmd.kind     = K_NOP;
    case (op_t'(in_op))
      OP_LOAD_W: begin
        if (!fi_ok) cmd.status = 1'b1;
        else if (lane_ok) begin
          cmd.kind     = K_WR_ROW;
          cmd.row_addr = ROW_AW'(in_feature_index) * ROW_AW'(LANES) + ROW_AW'(in_lane_index);
        end
      end
      OP_LOAD_BIAS: if (lane_ok) cmd.kind = K_WR_BIAS;
      OP_LOAD_HEAD: if (head_ok) cmd.kind = K_WR_HEAD;
      OP_RESET:     cmd.kind = K_RESET;
      OP_ADD, OP_SUB: begin
        if (!fi_ok) cmd.status = 1'b1;
        else cmd.kind = (op_t'(in_op) == OP_ADD) ? K_ADD : K_SUB;
      end
      OP_EVAL:      cmd.kind = K_EVAL;
      default:      cmd.kind = K_NOP;
    endcase
  end

endmodule

/* rtl/nnue_back.sv */
module nnue_back (
  input  logic                clk,
  input  logic                rst_n,
  input  nnue_pkg::cmd_t      q_cmd,
  input  logic                q_valid,
  output logic                q_pop,
  input  nnue_pkg::cfg_wr_t   cfg,
  output logic                out_valid,
  output logic                out_status,
  output logic signed [31:0]  out_score
);
  import nnue_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_WALK, S_DRAIN, S_MAG, S_MUL0, S_MUL1,
    S_PSUM, S_SIGN, S_BIAS, S_SAT
  } state_t;

  state_t state_r;
  cmd_t   cmd_r;
  logic [HEAD_W-1:0] idx_r;

  logic [14:0] clamp_r;
  logic [31:0] gain_r;
  logic [63:0] obias_r;

  logic signed [15:0] row_mem  [ROW_DEPTH];
  logic [31:0]        bias_mem [LANES];
  logic signed [15:0] head_mem [HEAD_DEPTH];
  logic [63:0]        acc_mem  [LANES];
  logic [LANES-1:0]   acc_vld_r;

  logic               upper;
  logic [LANE_W-1:0]  walk_lane;
  logic               walk_side;
  logic               last;

  logic signed [15:0] row_rd_r;
  logic [31:0]        bias_rd_r;
  logic signed [15:0] head_rd_r;
  logic [63:0]        acc_rd_r;
  logic               vld_rd_r;

  logic               p1_v_r, p2_v_r, p3_v_r, p4_v_r;
  logic [LANE_W-1:0]  p1_lane_r;
  logic               p1_side_r;
  logic [14:0]        a_r;
  logic signed [15:0] w2_r, w3_r;
  logic [29:0]        sq_r;
  logic signed [46:0] prod_r;
  logic signed [63:0] sum_r;
  logic               neg_r;
  logic [63:0]        mag_r, t0_r, t1_r;
  logic [WIDE_W-1:0]  wide_r;

  logic [31:0]        cur;
  logic [31:0]        other;
  logic [31:0]        acc_new;
  logic [14:0]        act;
  logic               acc_we;
  logic               is_walk_kind;
  logic signed [65:0] shifted;
  logic signed [31:0] sat_score;

  assign q_pop = (state_r == S_IDLE) && q_valid;
  assign upper = (idx_r >= HEAD_W'(LANES));
  assign walk_lane = upper ? LANE_W'(idx_r - HEAD_W'(LANES)) : LANE_W'(idx_r);
  assign walk_side = (cmd_r.kind == K_EVAL) ? (cmd_r.side ^ upper) : cmd_r.side;
  assign last = (cmd_r.kind == K_EVAL) ? (idx_r == HEAD_W'(HEAD_DEPTH - 1))
                                       : (idx_r == HEAD_W'(LANES - 1));
  assign is_walk_kind = (q_cmd.kind inside {K_RESET, K_ADD, K_SUB, K_EVAL});

  // lane datapath after the registered reads
  always_comb begin
    cur   = vld_rd_r ? (p1_side_r ? acc_rd_r[63:32] : acc_rd_r[31:0]) : 32'd0;
    other = vld_rd_r ? (p1_side_r ? acc_rd_r[31:0] : acc_rd_r[63:32]) : 32'd0;
    case (cmd_r.kind)
      K_ADD:   acc_new = cur + {{16{row_rd_r[15]}}, row_rd_r};
      K_SUB:   acc_new = cur - {{16{row_rd_r[15]}}, row_rd_r};
      K_RESET: acc_new = bias_rd_r;
      default: acc_new = cur;
    endcase
    if (cur[31]) act = 15'd0;
    else if (cur > {17'd0, clamp_r}) act = clamp_r;
    else act = cur[14:0];
  end

  assign acc_we = p1_v_r && (cmd_r.kind != K_EVAL);

  always_comb begin
    shifted = $signed(wide_r[WIDE_W-1:32]);
    if (shifted > 66'sh7fffffff) sat_score = 32'sh7fffffff;
    else if (shifted < -66'sh80000000) sat_score = 32'sh80000000;
    else sat_score = shifted[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      idx_r      <= '0;
      out_valid  <= 1'b0;
      out_status <= 1'b0;
      out_score  <= '0;
      p1_v_r     <= 1'b0;
      p2_v_r     <= 1'b0;
      p3_v_r     <= 1'b0;
      p4_v_r     <= 1'b0;
      acc_vld_r  <= '0;
      clamp_r    <= 15'd127;
      gain_r     <= 32'd65536;
      obias_r    <= 64'd0;
    end else begin
      out_valid  <= 1'b0;
      out_status <= 1'b0;
      out_score  <= '0;
      p1_v_r     <= (state_r == S_WALK);
      p2_v_r     <= p1_v_r && (cmd_r.kind == K_EVAL);
      p3_v_r     <= p2_v_r;
      p4_v_r     <= p3_v_r;
      if (acc_we) acc_vld_r[p1_lane_r] <= 1'b1;
      if (cfg.we) begin
        case (cfg_idx_t'(cfg.index))
          CFG_CLAMP: clamp_r <= cfg.data[14:0];
          CFG_GAIN:  gain_r  <= cfg.data[31:0];
          CFG_BIAS:  obias_r <= cfg.data;
          default:   ;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          idx_r <= '0;
          if (q_valid) state_r <= is_walk_kind ? S_WALK : S_LOAD;
        end
        S_LOAD: begin
          out_valid  <= 1'b1;
          out_status <= cmd_r.status;
          state_r    <= S_IDLE;
        end
        S_WALK: begin
          idx_r <= idx_r + HEAD_W'(1);
          if (last) state_r <= S_DRAIN;
        end
        S_DRAIN: begin
          if (!p1_v_r && !p2_v_r && !p3_v_r && !p4_v_r) begin
            if (cmd_r.kind == K_EVAL) state_r <= S_MAG;
            else begin
              out_valid <= 1'b1;
              state_r   <= S_IDLE;
            end
          end
        end
        S_MAG:  state_r <= S_MUL0;
        S_MUL0: state_r <= S_MUL1;
        S_MUL1: state_r <= S_PSUM;
        S_PSUM: state_r <= S_SIGN;
        S_SIGN: state_r <= S_BIAS;
        S_BIAS: state_r <= S_SAT;
        S_SAT: begin
          out_valid <= 1'b1;
          out_score <= sat_score;
          state_r   <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (state_r == S_LOAD && cmd_r.kind == K_WR_ROW) row_mem[cmd_r.row_addr] <= cmd_r.w16;
    row_rd_r <= row_mem[cmd_r.row_addr + ROW_AW'(walk_lane)];
  end

  always_ff @(posedge clk) begin
    if (state_r == S_LOAD && cmd_r.kind == K_WR_BIAS) bias_mem[cmd_r.lane[LANE_W-1:0]] <= cmd_r.v32;
    bias_rd_r <= bias_mem[walk_lane];
  end

  always_ff @(posedge clk) begin
    if (state_r == S_LOAD && cmd_r.kind == K_WR_HEAD) head_mem[cmd_r.lane[HEAD_W-1:0]] <= cmd_r.w16;
    head_rd_r <= head_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (acc_we) acc_mem[p1_lane_r] <= p1_side_r ? {acc_new, other} : {other, acc_new};
    acc_rd_r <= acc_mem[walk_lane];
    vld_rd_r <= acc_vld_r[walk_lane];
  end

  // lane pipeline and head arithmetic
  always_ff @(posedge clk) begin
    if (q_pop) cmd_r <= q_cmd;
    p1_lane_r <= walk_lane;
    p1_side_r <= walk_side;
    a_r       <= act;
    w2_r      <= head_rd_r;
    sq_r      <= a_r * a_r;
    w3_r      <= w2_r;
    prod_r    <= $signed({1'b0, sq_r}) * w3_r;
    if (q_pop) sum_r <= '0;
    else if (p4_v_r) sum_r <= sum_r + 64'(prod_r);
    case (state_r)
      S_MAG: begin
        neg_r <= sum_r[63];
        mag_r <= sum_r[63] ? 64'(-sum_r) : 64'(sum_r);
      end
      S_MUL0: t0_r <= mag_r[31:0] * gain_r;
      S_MUL1: t1_r <= mag_r[63:32] * gain_r;
      S_PSUM: wide_r <= WIDE_W'({t1_r, 32'd0}) + WIDE_W'(t0_r);
      S_SIGN: if (neg_r) wide_r <= -wide_r;
      S_BIAS: wide_r <= wide_r + {{(WIDE_W - 64){obias_r[63]}}, obias_r};
      default: ;
    endcase
  end

endmodule

/* rtl/nnue_accumulator_screlu_eval_core.sv */
// Commands enter through start/busy into a two-entry queue and run one at a
// time; each gives one result strobe on out_valid, which the receiver cannot
// stall. Reset, add row and sub row walk the accumulator memory one lane per
// cycle; evaluate walks both sides through the single read port of the
// accumulator and head-weight memories, then the four-stage lane pipeline and
// the split 64x32 gain multiply. A request that waits in the queue adds the
// time of the one ahead of it.
// Accumulators read as zero after reset through per-lane valid bits, so no
// clearing pass is needed. Configuration writes take effect at once.
module nnue_accumulator_screlu_eval_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_op,
  input  logic               in_perspective,
  input  logic [16:0]        in_feature_index,
  input  logic [8:0]         in_lane_index,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  output logic               out_status,
  output logic signed [31:0] out_score,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [63:0]        cfg_data
);
  import nnue_pkg::*;

  cmd_t    push_cmd;
  cmd_t    head_cmd;
  logic    push;
  logic    pop;
  logic    q_full;
  logic    q_valid;
  cfg_wr_t cfg;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  nnue_front u_front (
    .start            (start),
    .in_op            (in_op),
    .in_perspective   (in_perspective),
    .in_feature_index (in_feature_index),
    .in_lane_index    (in_lane_index),
    .in_value         (in_value),
    .q_full           (q_full),
    .busy             (busy),
    .push             (push),
    .cmd              (push_cmd)
  );

  nnue_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop       (pop),
    .head_cmd  (head_cmd),
    .not_empty (q_valid),
    .full      (q_full)
  );

  nnue_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_cmd      (head_cmd),
    .q_valid    (q_valid),
    .q_pop      (pop),
    .cfg        (cfg),
    .out_valid  (out_valid),
    .out_status (out_status),
    .out_score  (out_score)
  );

endmodule

/* rtl/nnue_checker.sv */
`include "nnue_accumulator_screlu_eval_core_assert.svh"

module nnue_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               busy,
  input logic               out_valid,
  input logic               out_status,
  input logic signed [31:0] out_score
);

  `NNUE_ASSERT_NEXT(a_reset_quiet, clk, !rst_n, !out_valid && !busy)
  `NNUE_ASSERT_NEXT(a_strobe_single, clk, out_valid, !out_valid)
  `NNUE_ASSERT_NOW(a_idle_zero, clk, rst_n, !out_valid, out_score == 32'sd0 && !out_status)
  `NNUE_ASSERT_NOW(a_flag_no_score, clk, rst_n, out_valid && out_status, out_score == 32'sd0)

endmodule

bind nnue_accumulator_screlu_eval_core nnue_checker u_checker (.*);

/* tb/tb.sv */
module tb;
  import nnue_pkg::*;

  localparam int FEAT_DIM = INPUT_DIM;
  localparam int WD_LIMIT = 20000;
  localparam logic [2:0] OP_NONE = 3'd7;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [2:0]         in_op = '0;
  logic               in_perspective = 1'b0;
  logic [16:0]        in_feature_index = '0;
  logic [8:0]         in_lane_index = '0;
  logic signed [31:0] in_value = '0;
  logic               out_valid;
  logic               out_status;
  logic signed [31:0] out_score;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [63:0]        cfg_data = '0;

  nnue_accumulator_screlu_eval_core uut (.*);

  always #5 clk = ~clk;

  // predictor state
  logic [14:0]        m_clamp;
  logic [31:0]        m_gain;
  logic signed [63:0] m_obias;
  logic signed [15:0] m_rows [int];
  logic [31:0]        m_biasv [LANES];
  logic signed [15:0] m_head [HEAD_DEPTH];
  logic [31:0]        m_acc [2][LANES];

  typedef struct packed {
    logic        status;
    logic [31:0] score;
  } verdict_t;

  verdict_t    pending_q [$];
  int          errors = 0;
  int          n_sent = 0;
  int          n_got = 0;
  int          n_evals = 0;
  int          idle_pct = 0;
  int          wd_count = 0;

  function automatic logic signed [15:0] sat16(logic signed [31:0] v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return -16'sh8000;
    return v[15:0];
  endfunction

  function automatic logic [31:0] screlu_score(logic side);
    logic signed [127:0] total;
    logic signed [127:0] a;
    logic signed [127:0] wide;
    logic signed [127:0] shifted;
    total = 0;
    for (int s = 0; s < 2; s++) begin
      for (int i = 0; i < LANES; i++) begin
        a = $signed(m_acc[side ^ s][i]);
        if (a < 0) a = 0;
        if (a > m_clamp) a = m_clamp;
        total += a * a * $signed(m_head[s * LANES + i]);
      end
    end
    wide = total * $signed({96'd0, m_gain}) + m_obias;
    shifted = wide >>> 32;
    if (shifted > 128'sh7fffffff) return 32'h7fffffff;
    if (shifted < -128'sh80000000) return 32'h80000000;
    return shifted[31:0];
  endfunction

  function automatic verdict_t predict(logic [2:0] op, logic side, logic [16:0] fi,
                                       logic [8:0] lane, logic signed [31:0] val);
    verdict_t r;
    r = '0;
    case (op)
      OP_LOAD_W: begin
        if (fi >= FEAT_DIM) r.status = 1'b1;
        else if (lane < LANES) m_rows[fi * LANES + lane] = sat16(val);
      end
      OP_LOAD_BIAS: if (lane < LANES) m_biasv[lane] = val;
      OP_LOAD_HEAD: if (lane < HEAD_DEPTH) m_head[lane] = sat16(val);
      OP_RESET: for (int i = 0; i < LANES; i++) m_acc[side][i] = m_biasv[i];
      OP_ADD, OP_SUB: begin
        if (fi >= FEAT_DIM) r.status = 1'b1;
        else for (int i = 0; i < LANES; i++) begin
          if (op == OP_ADD) m_acc[side][i] += {{16{m_rows[fi*LANES+i][15]}},
                                               m_rows[fi*LANES+i]};
          else m_acc[side][i] -= {{16{m_rows[fi*LANES+i][15]}}, m_rows[fi*LANES+i]};
        end
      end
      OP_EVAL: r.score = screlu_score(side);
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_request(logic [2:0] op, logic side, logic [16:0] fi,
                              logic [8:0] lane, logic signed [31:0] val);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_op <= op;
    in_perspective <= side;
    in_feature_index <= fi;
    in_lane_index <= lane;
    in_value <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_q.insert(pending_q.size(), predict(op, side, fi, lane, val));
    if (op == OP_EVAL) n_evals++;
    n_sent++;
  endtask

  task automatic drain;
    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  task automatic write_cfg(cfg_idx_t idx, logic [63:0] data);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_CLAMP: m_clamp = data[14:0];
      CFG_GAIN:  m_gain = data[31:0];
      CFG_BIAS:  m_obias = data;
      default: ;
    endcase
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_q.size() == 0) begin
        $display("%0t unexpected result status=%0b score=%0d", $time, out_status, out_score);
        errors++;
      end else begin
        verdict_t e;
        e = pending_q.pop_front();
        if (e.status !== out_status) begin
          $display("%0t status expected %0b actual %0b", $time, e.status, out_status);
          errors++;
        end
        if (e.score !== out_score) begin
          $display("%0t score expected %0d actual %0d", $time, $signed(e.score), out_score);
          errors++;
        end
        n_got++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) wd_count <= 0;
    else wd_count <= wd_count + 1;
    if (wd_count >= WD_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  int used_rows [$];

  task automatic load_row(int r, bit extreme);
    for (int i = 0; i < LANES; i++)
      send_request(OP_LOAD_W, 1'b0, r[16:0], i[8:0],
                   extreme ? (i[0] ? 32'sh7fffffff : 32'sh80000000) : $urandom());
    used_rows.insert(used_rows.size(), r);
  endtask

  task automatic test_setup;
    for (int i = 0; i < LANES; i++) send_request(OP_LOAD_BIAS, 1'b0, '0, i[8:0],
                                                 $signed($urandom_range(400)) - 100);
    for (int i = 0; i < HEAD_DEPTH; i++) send_request(OP_LOAD_HEAD, 1'b0, '0, i[8:0],
                                                      $urandom());
    load_row(FEAT_DIM - 1, 1'b1);
  endtask

  task automatic test_directed;
    send_request(OP_LOAD_W, 1'b1, 17'h1ffff, 9'd3, 32'sd5);
    send_request(OP_LOAD_W, 1'b0, 17'(FEAT_DIM), 9'd3, 32'sd5);
    send_request(OP_LOAD_W, 1'b0, 17'd0, 9'h1ff, 32'sd5);
    send_request(OP_LOAD_BIAS, 1'b0, 17'h1ffff, 9'h1ff, 32'sh7fffffff);
    send_request(OP_LOAD_HEAD, 1'b1, 17'h1ffff, 9'h1ff, 32'sh80000000);
    send_request(OP_ADD, 1'b1, 17'h1ffff, 9'd0, 0);
    send_request(OP_SUB, 1'b0, 17'(FEAT_DIM), 9'd0, 0);
    send_request(OP_NONE, 1'b1, 17'h1ffff, 9'h1ff, 32'shffffffff);
    send_request(OP_EVAL, 1'b0, '0, '0, 0);
    send_request(OP_RESET, 1'b0, '0, '0, 0);
    send_request(OP_RESET, 1'b1, '0, '0, 0);
    send_request(OP_ADD, 1'b0, 17'(FEAT_DIM - 1), '0, 0);
    send_request(OP_ADD, 1'b1, 17'(FEAT_DIM - 1), '0, 0);
    send_request(OP_EVAL, 1'b0, '0, '0, 0);
    send_request(OP_SUB, 1'b1, 17'(FEAT_DIM - 1), '0, 0);
    send_request(OP_EVAL, 1'b1, '0, '0, 0);
  endtask

  task automatic test_random(int n);
    int r;
    for (int k = 0; k < n; k++) begin
      r = used_rows[$urandom_range(used_rows.size() - 1)];
      case ($urandom_range(9))
        0: send_request(OP_LOAD_W, 1'($urandom()), 17'(used_rows[0]),
                        9'($urandom_range(LANES - 1)), $urandom());
        1: send_request(OP_LOAD_HEAD, 1'($urandom()), 17'($urandom()),
                        9'($urandom_range(HEAD_DEPTH - 1)), $urandom());
        2: send_request(OP_LOAD_BIAS, 1'($urandom()), 17'($urandom()),
                        9'($urandom_range(LANES - 1)), $urandom());
        3: send_request(OP_RESET, 1'($urandom()), 17'($urandom()), 9'($urandom()),
                        $urandom());
        4, 5: send_request(OP_ADD, 1'($urandom()), 17'(r), 9'($urandom()), $urandom());
        6: send_request(OP_SUB, 1'($urandom()), 17'(r), 9'($urandom()), $urandom());
        7: send_request($urandom_range(1) ? OP_ADD : OP_NONE, 1'($urandom()),
                        17'(FEAT_DIM + $urandom_range(131071 - FEAT_DIM)), 9'($urandom()),
                        $urandom());
        default: send_request(OP_EVAL, 1'($urandom()), 17'($urandom()), 9'($urandom()),
                              $urandom());
      endcase
    end
  endtask

  task automatic test_config_sweep;
    int pcts [4] = '{0, 50, 0, 24};
    for (int p = 0; p < 4; p++) begin
      idle_pct = pcts[p];
      case (p)
        0: begin write_cfg(CFG_CLAMP, 64'd1); write_cfg(CFG_GAIN, 64'hffffffff);
                 write_cfg(CFG_BIAS, 64'h7fffffffffffffff); end
        1: begin write_cfg(CFG_CLAMP, 64'd32767); write_cfg(CFG_GAIN, 64'd0);
                 write_cfg(CFG_BIAS, 64'h8000000000000000); end
        2: begin write_cfg(CFG_CLAMP, 64'd0); write_cfg(CFG_GAIN, 64'($urandom()));
                 write_cfg(CFG_BIAS, {$urandom(), $urandom()}); end
        default: begin write_cfg(CFG_CLAMP, 64'd127); write_cfg(CFG_GAIN, 64'd65536);
                       write_cfg(CFG_BIAS, 64'd0); end
      endcase
      test_random(33);
    end
  endtask

  initial begin
    m_clamp = 15'd127;
    m_gain = 32'd65536;
    m_obias = '0;
    foreach (m_acc[s, i]) m_acc[s][i] = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_setup();
    test_directed();
    test_config_sweep();
    drain();
    $display("sent %0d requests, %0d results checked, %0d evaluations", n_sent, n_got, n_evals);
    $display("covered loads, resets, row updates, bad indices, four register settings");
    if (errors == 0 && pending_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
